FILE: hdl/bfbp_pkg.sv
// Shared constants, status codes and controller/datapath interface types
// for the best-fit bin packer. No dependencies.
package bfbp_pkg;

   localparam int MAX_BINS   = 64;
   localparam int SIZE_WIDTH = 16;
   localparam int IDX_WIDTH  = $clog2(MAX_BINS);
   localparam int CNT_WIDTH  = $clog2(MAX_BINS + 1);

   localparam logic [SIZE_WIDTH-1:0] CAP_RESET = {SIZE_WIDTH{1'b1}};
   localparam logic [CNT_WIDTH-1:0]  BINS_FULL = CNT_WIDTH'(MAX_BINS);

   localparam logic [1:0] STATUS_PLACED   = 2'd0;
   localparam logic [1:0] STATUS_NEW_BIN  = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic load;     // latch an accepted item
      logic scan_rd;  // read the bin at the scan pointer and advance
      logic update;   // commit the placement and present the result
   } bfbp_cmd_type;

   typedef struct packed {
      logic skip_scan; // item needs no scan: oversize or no open bins
      logic last_rd;   // scan pointer is at the last open bin
   } bfbp_stat_type;

endpackage

FILE: hdl/bfbp_ctrl.sv
// Sequencing state machine for the best-fit bin packer.
// Depends on bfbp_pkg for the command and status types.
module bfbp_ctrl
   import bfbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  bfbp_stat_type stat,
   output bfbp_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_LAST   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0] state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.skip_scan ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.last_rd) state_in = ST_LAST;
         end
         // compare the last bin read
         ST_LAST: state_in = ST_UPDATE;
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: hdl/bfbp_dp.sv
// Datapath of the best-fit bin packer: capacity register, bin fill memory,
// scan compare with best-fit tracking, and result registers. Uses bfbp_pkg.
module bfbp_dp
   import bfbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SIZE_WIDTH-1:0] req_item_size,
   input  logic                  req_restart,
   input  logic                  csr_wr_en,
   input  logic [SIZE_WIDTH-1:0] csr_wr_data,
   input  bfbp_cmd_type          cmd,
   output bfbp_stat_type         stat,
   output logic                  rsp_valid,
   output logic [IDX_WIDTH-1:0]  rsp_bin_index,
   output logic [1:0]            rsp_status,
   output logic [CNT_WIDTH-1:0]  rsp_bins_used
);

   logic [SIZE_WIDTH-1:0] bin_mem [MAX_BINS];

   logic [SIZE_WIDTH-1:0] cap_ff;
   logic [CNT_WIDTH-1:0]  open_ff, open_in;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic                  oversize_ff;
   logic [IDX_WIDTH-1:0]  ptr_ff;
   logic [SIZE_WIDTH-1:0] rd_data_ff;
   logic                  cmp_vld_ff;
   logic [IDX_WIDTH-1:0]  cmp_idx_ff;
   logic [SIZE_WIDTH:0]   best_space_ff;
   logic [IDX_WIDTH-1:0]  best_idx_ff;
   logic [SIZE_WIDTH-1:0] best_fill_ff;
   logic                  found_ff;
   logic                  rsp_valid_ff;
   logic [IDX_WIDTH-1:0]  rsp_index_ff;
   logic [1:0]            rsp_status_ff;

   logic                  oversize_now;
   logic [CNT_WIDTH-1:0]  open_start;
   logic [SIZE_WIDTH-1:0] space;
   logic                  better;
   logic                  table_full;

   assign oversize_now   = (req_item_size > cap_ff);
   assign open_start     = req_restart ? '0 : open_ff;
   assign stat.skip_scan = oversize_now || (open_start == '0);
   assign stat.last_rd   = ({1'b0, ptr_ff} == CNT_WIDTH'(open_ff - 1'b1));

   // a bin filled past the capacity has no room at all
   assign space  = cap_ff - rd_data_ff;
   assign better = cmp_vld_ff && (rd_data_ff <= cap_ff) && (size_ff <= space) &&
                   ({1'b0, space} < best_space_ff);

   assign table_full = (open_ff == BINS_FULL);

   always_comb begin
      open_in = open_ff;
      if (cmd.load)
         open_in = open_start;
      else if (cmd.update && !oversize_ff && !found_ff && !table_full)
         open_in = open_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         open_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         open_ff      <= open_in;
         cmp_vld_ff   <= cmd.scan_rd;
         rsp_valid_ff <= cmd.update;
      end
   end

   // scan pointer, memory read and best-fit tracking
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         size_ff       <= req_item_size;
         oversize_ff   <= oversize_now;
         ptr_ff        <= '0;
         found_ff      <= 1'b0;
         best_space_ff <= {1'b0, cap_ff} + 1'b1;
      end else begin
         if (cmd.scan_rd) ptr_ff <= ptr_ff + 1'b1;
         if (better) begin
            found_ff      <= 1'b1;
            best_space_ff <= {1'b0, space};
            best_idx_ff   <= cmp_idx_ff;
            best_fill_ff  <= rd_data_ff;
         end
      end
      rd_data_ff <= bin_mem[ptr_ff];
      cmp_idx_ff <= ptr_ff;
   end

   // commit: add to the best bin, or open a new one if the table is not full
   always_ff @(posedge clock) begin
      if (cmd.update && !oversize_ff) begin
         if (found_ff)
            bin_mem[best_idx_ff] <= best_fill_ff + size_ff;
         else if (!table_full)
            bin_mem[open_ff[IDX_WIDTH-1:0]] <= size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         priority if (oversize_ff) begin
            rsp_status_ff <= STATUS_OVERSIZE;
            rsp_index_ff  <= '0;
         end else if (found_ff) begin
            rsp_status_ff <= STATUS_PLACED;
            rsp_index_ff  <= best_idx_ff;
         end else if (table_full) begin
            rsp_status_ff <= STATUS_FULL;
            rsp_index_ff  <= '0;
         end else begin
            rsp_status_ff <= STATUS_NEW_BIN;
            rsp_index_ff  <= open_ff[IDX_WIDTH-1:0];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_index_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_bins_used = open_ff;

endmodule

FILE: hdl/best_fit_bin_packer.sv
// Best-fit bin packer top level: controller plus datapath. Uses bfbp_pkg.
// An item is accepted only while idle (busy low). The controller then scans the
// open bins, reading the bin fill memory one bin per cycle, compares the last bin
// read and commits the placement; the result strobe is registered from the commit.
// The scan is skipped when the item is oversize or no bin is open. Results are strobed one cycle, unstalled.
// Reset (synchronous) closes all bins and sets the capacity to 65535.
module best_fit_bin_packer
   import bfbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [SIZE_WIDTH-1:0] req_item_size,
   input  logic                  req_restart,
   input  logic                  csr_wr_en,
   input  logic [SIZE_WIDTH-1:0] csr_wr_data,
   output logic                  rsp_valid,
   output logic [IDX_WIDTH-1:0]  rsp_bin_index,
   output logic [1:0]            rsp_status,
   output logic [CNT_WIDTH-1:0]  rsp_bins_used
);

   bfbp_cmd_type  cmd;
   bfbp_stat_type stat;

   bfbp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bfbp_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_item_size (req_item_size),
      .req_restart   (req_restart),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_status    (rsp_status),
      .rsp_bins_used (rsp_bins_used)
   );

endmodule

FILE: test/bfbp_checker.sv
// Scoreboard for the best-fit bin packer: watches the item, result and
// register ports, predicts each placement and compares it. Uses bfbp_pkg.
module bfbp_checker
   import bfbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [SIZE_WIDTH-1:0] req_item_size,
   input  logic                  req_restart,
   input  logic                  csr_wr_en,
   input  logic [SIZE_WIDTH-1:0] csr_wr_data,
   input  logic                  rsp_valid,
   input  logic [IDX_WIDTH-1:0]  rsp_bin_index,
   input  logic [1:0]            rsp_status,
   input  logic [CNT_WIDTH-1:0]  rsp_bins_used,
   output int                    pending,
   output int                    fail_count
);

   typedef struct packed {
      logic [IDX_WIDTH-1:0] bin;
      logic [1:0]           status;
      logic [CNT_WIDTH-1:0] used;
   } placement_type;

   logic [SIZE_WIDTH-1:0] bin_level [MAX_BINS];
   logic [SIZE_WIDTH-1:0] capacity = CAP_RESET;
   int                    open_count = 0;
   placement_type         placements_due [$];
   int                    shown = 0;

   function automatic void log_failure(input string msg);
      fail_count++;
      if (shown < 10) begin
         shown++;
         $display("%0t: %s", $time, msg);
      end
   endfunction

   // Best fit: smallest remaining room that still holds the item, lowest index on a tie.
   function automatic placement_type place_item(input logic [SIZE_WIDTH-1:0] size,
                                                input logic restart);
      placement_type         p;
      logic [SIZE_WIDTH:0]   best_room;
      logic [SIZE_WIDTH-1:0] room;
      int                    best;
      int                    j;
      bit                    found;

      if (restart)
         open_count = 0;
      p.bin     = '0;
      best_room = {1'b0, capacity} + 1'b1;
      best      = 0;
      found     = 1'b0;
      if (size > capacity) begin
         p.status = STATUS_OVERSIZE;
      end else begin
         for (j = 0; j < open_count; j++) begin
            // an overfull bin (capacity lowered under it) has no room at all
            if (bin_level[j] <= capacity) begin
               room = capacity - bin_level[j];
               if (size <= room && {1'b0, room} < best_room) begin
                  best_room = {1'b0, room};
                  best      = j;
                  found     = 1'b1;
               end
            end
         end
         if (found) begin
            bin_level[best] = bin_level[best] + size;
            p.bin           = IDX_WIDTH'(best);
            p.status        = STATUS_PLACED;
         end else if (open_count >= MAX_BINS) begin
            p.status = STATUS_FULL;
         end else begin
            bin_level[open_count] = size;
            p.bin                 = IDX_WIDTH'(open_count);
            open_count++;
            p.status              = STATUS_NEW_BIN;
         end
      end
      p.used = CNT_WIDTH'(open_count);
      return p;
   endfunction

   always @(posedge clock) begin
      placement_type want;

      if (reset) begin
         capacity   = CAP_RESET;
         open_count = 0;
         fail_count = 0;
         placements_due.delete();
      end else begin
         if (csr_wr_en)
            capacity = csr_wr_data;
         if (rsp_valid) begin
            if (placements_due.size() == 0) begin
               log_failure($sformatf("unexpected result: bin %0d status %0d used %0d",
                                     rsp_bin_index, rsp_status, rsp_bins_used));
            end else begin
               want = placements_due.pop_front();
               if (rsp_bin_index !== want.bin || rsp_status !== want.status ||
                   rsp_bins_used !== want.used)
                  log_failure($sformatf(
                     "mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d (bin/status/used)",
                     want.bin, want.status, want.used,
                     rsp_bin_index, rsp_status, rsp_bins_used));
            end
         end
         if (start && !busy)
            placements_due.push_back(place_item(req_item_size, req_restart));
      end
      pending <= placements_due.size();
   end

endmodule

FILE: test/tb_top.sv
// Testbench top for the best-fit bin packer: drives items and capacity
// writes, gives the verdict. Uses bfbp_pkg, best_fit_bin_packer, bfbp_checker.
module tb_top;
   import bfbp_pkg::*;

   localparam int RANDOM_ITEMS = 825;
   localparam int PHASES       = 9;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  start         = 1'b0;
   logic [SIZE_WIDTH-1:0] req_item_size = '0;
   logic                  req_restart   = 1'b0;
   logic                  csr_wr_en     = 1'b0;
   logic [SIZE_WIDTH-1:0] csr_wr_data   = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [IDX_WIDTH-1:0]  rsp_bin_index;
   logic [1:0]            rsp_status;
   logic [CNT_WIDTH-1:0]  rsp_bins_used;
   int                    pending;
   int                    fail_count;
   int                    cap_now = int'(CAP_RESET);
   bit                    gaps_on = 1'b0;

   best_fit_bin_packer dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item_size (req_item_size),
      .req_restart   (req_restart),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_status    (rsp_status),
      .rsp_bins_used (rsp_bins_used)
   );

   bfbp_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item_size (req_item_size),
      .req_restart   (req_restart),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_status    (rsp_status),
      .rsp_bins_used (rsp_bins_used),
      .pending       (pending),
      .fail_count    (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic place(input int size, input bit restart);
      start         <= 1'b1;
      req_item_size <= SIZE_WIDTH'(size);
      req_restart   <= restart;
      do @(posedge clock); while (busy);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         // sometimes let the block drain first so the gap lands while it is idle
         if ($urandom_range(0, 1) == 1)
            do @(posedge clock); while (busy);
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_capacity(input int value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SIZE_WIDTH'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_now = value;
   endtask

   function automatic int pick_size(input int kind, input int cap);
      case (kind)
         // more than half the capacity: every item opens a bin, so the table fills
         0, 1:    return $urandom_range(cap / 2 + 1, cap);
         2, 3, 4: return $urandom_range(0, cap / 4);
         5: begin
            if ($urandom_range(0, 3) == 0)
               return 0;
            return cap - $urandom_range(0, cap / 8);
         end
         default: return $urandom_range(0, cap);
      endcase
   endfunction

   initial begin
      int caps [PHASES];
      int ph;
      int k;
      int len;
      int kind;
      int remaining;
      int size;
      bit restart;
      bit first_set;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full-range sizes, zero size, tie on equal room
      set_capacity(65535);
      place(0, 1);
      place(65535, 0);
      place(65535, 0);
      place(0, 0);
      place(1, 0);
      place(16'hAAAA, 1);
      place(16'h5555, 0);

      // lower capacity under full bins, oversize with and without restart
      set_capacity(10);
      place(11, 0);
      place(0, 0);
      place(11, 1);
      place(0, 0);
      place(4, 0);
      place(7, 0);
      place(3, 0);
      place(6, 0);
      place(10, 0);
      place(65535, 0);
      place(6, 1);
      place(6, 0);
      place(4, 0);

      caps = '{1, 65535, $urandom_range(2, 200), 2, $urandom_range(1, 65535), 40000,
               $urandom_range(1, 1000), 65535, 3};
      for (ph = 0; ph < PHASES; ph++) begin
         set_capacity(caps[ph]);
         remaining = RANDOM_ITEMS / PHASES;
         first_set = 1'b1;
         gaps_on   = (ph != PHASES - 1);
         while (remaining > 0) begin
            kind = $urandom_range(0, 9);
            len  = (kind < 2) ? $urandom_range(60, 72) : $urandom_range(3, 30);
            for (k = 0; k < len && remaining > 0; k++) begin
               // a set opened without restart keeps bins filled under the old capacity
               restart = (k == 0) ? (first_set ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0;
               size    = pick_size(kind, cap_now);
               if ($urandom_range(0, 9) == 0) begin
                  if ($urandom_range(0, 2) == 0 && cap_now < 65535)
                     size = cap_now + 1;
                  else
                     size = $urandom_range(0, 65535);
                  restart = restart | ($urandom_range(0, 15) == 0);
               end
               if (ph != PHASES - 1 && remaining % 30 == 0)
                  gaps_on = ($urandom_range(0, 2) != 0);
               place(size, restart);
               remaining--;
            end
            first_set = 1'b0;
         end
      end

      settle();
      repeat (MAX_BINS + 8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hdl/bfbp_pkg.sv
hdl/bfbp_ctrl.sv
hdl/bfbp_dp.sv
hdl/best_fit_bin_packer.sv
test/bfbp_checker.sv
test/tb_top.sv
